// ===== hdl/btmx_pkg.sv =====
// shared constants and types for the binary trie max-xor block
// no dependencies; imported by the top level and its testbench
package btmx_pkg;

  localparam int KEY_BITS  = 32;
  localparam int NODE_POOL = 4096;

  localparam int VALUE_W = 32;
  localparam int PTR_W   = $clog2(NODE_POOL);
  localparam int CNT_W   = $clog2(NODE_POOL + 1);
  localparam int LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int ENTRY_W = 2 * PTR_W;

  // two child links of one node, index is the key bit
  typedef logic [1:0][PTR_W-1:0] link_pair_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ANSWERED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_LINK = 4'b0100,
    S_FILL = 4'b1000
  } state_e;

endpackage

// ===== hdl/btmx_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/binary_trie_max_xor.sv =====
// binary trie max-xor engine: walks a node trie held in btmx_ram
// depends on btmx_pkg and btmx_ram
//
// usage: drive cmd_i and value_i with start high; the word is taken at a
// rising edge where start is high and busy is low. cmd_i low inserts the
// key, high asks for the largest xor of value_i with any stored key.
// each word gives one result on status_o and max_xor_o, marked by done_o
// for exactly one cycle; the receiver cannot hold it off.
// the trie walk reads one node per key bit from the node ram, which has a
// registered read; the next address comes straight from the read data.
// query: walk from the top key bit down to bit 0, then the strobe is registered.
// query on an empty trie: strobe on the cycle after the word is taken.
// insert: walk down to the first missing link, link the first new node, then
// write one allocated node per remaining level; a duplicate key ends at the
// bottom of the walk, a rejected insert where the path leaves the trie. a
// new word can be taken in the strobe cycle.
// reset empties the trie (root links null, one node used); the node ram
// needs no clearing because every node is written when it is allocated.
module binary_trie_max_xor
  import btmx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               busy,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [VALUE_W-1:0] max_xor_o
);

  state_e                state_q, state_d;
  logic                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [KEY_BITS-1:0]   best_q, best_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [LVL_W-1:0]      lvl_m1;
  logic                  at_root_q, at_root_d;
  logic [PTR_W-1:0]      node_q, node_d;
  link_pair_t            ent_q, ent_d;
  logic                  side_q, side_d;
  link_pair_t            root_q, root_d;
  logic [CNT_W-1:0]      used_q, used_d;
  logic                  keys_q, keys_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [KEY_BITS-1:0]   res_q, res_d;

  link_pair_t            cur;
  link_pair_t            wpair;
  logic                  bit_k;
  logic [PTR_W-1:0]      nxt;
  logic [PTR_W-1:0]      nu;
  logic [CNT_W:0]        need_sum;

  logic                  ram_we, ram_re;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  btmx_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_POOL)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wpair),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur      = at_root_q ? root_q : link_pair_t'(ram_rdata);
  assign bit_k    = key_q[lvl_q];
  assign lvl_m1   = lvl_q - LVL_W'(1);
  assign nu       = used_q[PTR_W-1:0];
  // nodes in use plus the fresh path below this level
  assign need_sum = {1'b0, used_q} + (CNT_W+1)'(lvl_q) + (CNT_W+1)'(1);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    best_d    = best_q;
    lvl_d     = lvl_q;
    at_root_d = at_root_q;
    node_d    = node_q;
    ent_d     = ent_q;
    side_d    = side_q;
    root_d    = root_q;
    used_d    = used_q;
    keys_d    = keys_q;
    done_d    = 1'b0;
    status_d  = status_q;
    res_d     = res_q;
    nxt       = '0;
    wpair     = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d     = cmd_i;
          key_d     = KEY_BITS'(value_i);
          best_d    = '0;
          lvl_d     = LVL_W'(KEY_BITS - 1);
          at_root_d = 1'b1;
          node_d    = '0;
          if (cmd_i == CMD_QUERY && !keys_q) begin
            done_d   = 1'b1;
            status_d = STAT_EMPTY;
            res_d    = '0;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (cmd_q == CMD_INSERT) begin
          nxt = cur[bit_k];
          if (nxt == '0) begin
            if (need_sum > (CNT_W+1)'(NODE_POOL)) begin
              done_d   = 1'b1;
              status_d = STAT_FULL;
              res_d    = '0;
              state_d  = S_IDLE;
            end else begin
              ent_d   = cur;
              side_d  = bit_k;
              state_d = S_LINK;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = nxt;
            node_d    = nxt;
            at_root_d = 1'b0;
            if (lvl_q == '0) begin
              // key already present
              done_d   = 1'b1;
              status_d = STAT_INSERTED;
              res_d    = '0;
              keys_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              lvl_d = lvl_m1;
            end
          end
        end else begin
          // prefer the opposite bit
          if (cur[~bit_k] != '0) begin
            nxt           = cur[~bit_k];
            best_d[lvl_q] = 1'b1;
          end else begin
            nxt = cur[bit_k];
          end
          ram_re    = 1'b1;
          ram_raddr = nxt;
          node_d    = nxt;
          at_root_d = 1'b0;
          if (nxt == '0 || lvl_q == '0) begin
            done_d   = 1'b1;
            status_d = STAT_ANSWERED;
            res_d    = best_d;
            state_d  = S_IDLE;
          end else begin
            lvl_d = lvl_m1;
          end
        end
      end

      S_LINK: begin
        if (node_q == '0) begin
          root_d[side_q] = nu;
        end else begin
          wpair         = ent_q;
          wpair[side_q] = nu;
          ram_we        = 1'b1;
          ram_waddr     = node_q;
        end
        state_d = S_FILL;
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = nu;
        used_d    = used_q + CNT_W'(1);
        if (lvl_q == '0) begin
          done_d   = 1'b1;
          status_d = STAT_INSERTED;
          res_d    = '0;
          keys_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          wpair[key_q[lvl_m1]] = PTR_W'(used_q + CNT_W'(1));
          lvl_d                = lvl_m1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      root_q  <= '0;
      used_q  <= CNT_W'(1);
      keys_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      used_q  <= used_d;
      keys_q  <= keys_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    best_q    <= best_d;
    lvl_q     <= lvl_d;
    at_root_q <= at_root_d;
    node_q    <= node_d;
    ent_q     <= ent_d;
    side_q    <= side_d;
    status_q  <= status_d;
    res_q     <= res_d;
  end

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign max_xor_o = VALUE_W'(res_q);

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a word is in flight");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted word neither started nor answered");

  a_pool_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NODE_POOL))
    else $error("node pool overrun");

  a_fill_in_pool : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (used_q < CNT_W'(NODE_POOL)))
    else $error("allocation past the end of the pool");

  a_answer_needs_keys : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_ANSWERED) |-> keys_q)
    else $error("query answered on an empty trie");

endmodule

// ===== tb/sv/binary_trie_max_xor_tb.sv =====
// self-checking testbench for binary_trie_max_xor: insert and max-xor query words
// depends on btmx_pkg and the binary_trie_max_xor rtl; keeps its own trie to predict results
module binary_trie_max_xor_tb
  import btmx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_WORDS = 1250;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } trie_word_t;

  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] max_xor;
  } trie_result_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               cmd_i   = 1'b0;
  logic [VALUE_W-1:0] value_i = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic [VALUE_W-1:0] max_xor_o;

  binary_trie_max_xor u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .cmd_i     (cmd_i),
    .value_i   (value_i),
    .busy      (busy),
    .done_o    (done_o),
    .status_o  (status_o),
    .max_xor_o (max_xor_o)
  );

  always #10 clk_i = ~clk_i;

  // predicted trie: node 0 is the root, link 0 means null
  int unsigned  root_child[2];
  int unsigned  pool_child[NODE_POOL][2];
  int unsigned  nodes_taken = 1;
  bit           any_key     = 1'b0;

  trie_word_t   word_q[$];
  trie_result_t owed_results[$];

  int unsigned  mismatches   = 0;
  int unsigned  words_sent   = 0;
  int unsigned  results_seen = 0;
  int unsigned  stall_cycles = 0;

  function automatic int unsigned read_child(int unsigned node, bit side);
    if (node == 0) return root_child[side];
    if (node >= NODE_POOL) return 0;
    return pool_child[node][side];
  endfunction

  function automatic void write_child(int unsigned node, bit side, int unsigned target);
    if (node == 0) root_child[side] = target;
    else if (node < NODE_POOL) pool_child[node][side] = target;
  endfunction

  function automatic void predict_word(logic cmd, logic [VALUE_W-1:0] value);
    logic [63:0]  key;
    logic [63:0]  best;
    int unsigned  node;
    int unsigned  next;
    int unsigned  need;
    bit           bit_now;
    trie_result_t res;
    key = 64'(value);
    if (KEY_BITS < 64) key &= (64'd1 << KEY_BITS) - 64'd1;
    node = 0;
    best = '0;
    res.max_xor = '0;
    if (cmd == CMD_INSERT) begin
      // count fresh nodes first, a full pool rejects the whole key
      need = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        next = read_child(node, key[i]);
        if (next == 0) begin
          need = i + 1;
          break;
        end
        node = next;
      end
      if (nodes_taken + need > NODE_POOL) begin
        res.status = STAT_FULL;
      end else begin
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          next = read_child(node, key[i]);
          if (next == 0) begin
            next = nodes_taken;
            nodes_taken++;
            if (next < NODE_POOL) begin
              pool_child[next][0] = 0;
              pool_child[next][1] = 0;
            end
            write_child(node, key[i], next);
          end
          node = next;
        end
        any_key = 1'b1;
        res.status = STAT_INSERTED;
      end
    end else if (!any_key) begin
      res.status = STAT_EMPTY;
    end else begin
      // greedy walk toward the opposite bit
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        bit_now = key[i];
        next = read_child(node, ~bit_now);
        if (next != 0) begin
          best[i] = 1'b1;
        end else begin
          next = read_child(node, bit_now);
          if (next == 0) break;
        end
        node = next;
      end
      res.status  = STAT_ANSWERED;
      res.max_xor = best[VALUE_W-1:0];
    end
    owed_results.push_back(res);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 8);
    return $urandom_range(20, 90);
  endfunction

  // driver: one word per handshake, bursts separated by random gaps
  bit                 fire;
  bit                 next_start;
  trie_word_t         next_word;
  int unsigned        gap_left   = 0;
  int unsigned        burst_left = 1;
  logic               took_word  = 1'b0;
  logic               took_cmd   = 1'b0;
  logic [VALUE_W-1:0] took_value = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      took_word <= 1'b0;
    end else begin
      fire = start && !busy;
      took_word  <= fire;
      took_cmd   <= cmd_i;
      took_value <= value_i;
      if (fire) words_sent++;
      if (fire || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          next_start = 1'b0;
        end else if (word_q.size() > 0) begin
          next_word  = word_q.pop_front();
          next_start = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = pick_gap();
          end else begin
            burst_left--;
          end
        end else begin
          next_start = 1'b0;
        end
        start <= next_start;
        if (next_start) begin
          cmd_i   <= next_word.cmd;
          value_i <= next_word.value;
        end else begin
          cmd_i   <= 1'($urandom_range(0, 1));
          value_i <= $urandom;
        end
      end
    end
  end

  // predict between edges so a strobe never races the word it follows
  always @(negedge clk_i) begin
    if (took_word) predict_word(took_cmd, took_value);
  end

  // monitor: every strobe is taken, the receiver never stalls
  trie_result_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d max_xor %h",
                 $time, status_o, max_xor_o);
      end else begin
        exp_res = owed_results.pop_front();
        if (status_o !== exp_res.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                   $time, exp_res.status, exp_res.status.name(), status_o);
        end
        if (max_xor_o !== exp_res.max_xor) begin
          mismatches++;
          $display("%0t: max_xor mismatch, expected %h, actual %h",
                   $time, exp_res.max_xor, max_xor_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("binary_trie_max_xor verification failed");
      $finish;
    end
  end

  function automatic void add_word(logic cmd, logic [VALUE_W-1:0] value);
    trie_word_t w;
    w.cmd   = cmd;
    w.value = value;
    word_q.push_back(w);
  endfunction

  initial begin
    logic [VALUE_W-1:0] cluster[4];
    logic [VALUE_W-1:0] inserted[$];
    logic [VALUE_W-1:0] v;
    int unsigned        r;

    // empty trie, extremes, duplicates, opposite patterns
    add_word(CMD_QUERY,  32'h0000_0000);
    add_word(CMD_QUERY,  32'hFFFF_FFFF);
    add_word(CMD_INSERT, 32'h0000_0000);
    add_word(CMD_QUERY,  32'h0000_0000);
    add_word(CMD_QUERY,  32'hFFFF_FFFF);
    add_word(CMD_INSERT, 32'h0000_0000);
    add_word(CMD_INSERT, 32'hFFFF_FFFF);
    add_word(CMD_QUERY,  32'h0000_0000);
    add_word(CMD_QUERY,  32'h8000_0000);
    add_word(CMD_INSERT, 32'h8000_0000);
    add_word(CMD_INSERT, 32'h0000_0001);
    add_word(CMD_QUERY,  32'h7FFF_FFFF);
    add_word(CMD_QUERY,  32'hAAAA_AAAA);
    add_word(CMD_INSERT, 32'h5555_5555);
    add_word(CMD_QUERY,  32'h5555_5555);
    add_word(CMD_QUERY,  32'hAAAA_AAAA);
    add_word(CMD_INSERT, 32'hFFFF_FFFF);
    add_word(CMD_QUERY,  32'hFFFF_FFFE);
    inserted = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h5555_5555};

    for (int k = 0; k < 4; k++) cluster[k] = $urandom;

    // random inserts fill the pool part way through, so rejects come naturally
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        v = $urandom;
        add_word(CMD_INSERT, v);
        inserted.push_back(v);
      end else if (r < 40) begin
        v = {cluster[$urandom_range(0, 3)][VALUE_W-1:12], 12'($urandom)};
        add_word(CMD_INSERT, v);
        inserted.push_back(v);
      end else if (r < 50) begin
        // duplicate, or a near neighbor needing only a few nodes
        v = inserted[$urandom_range(0, inserted.size() - 1)];
        if ($urandom_range(0, 1)) v ^= 32'h1 << $urandom_range(0, 3);
        add_word(CMD_INSERT, v);
        inserted.push_back(v);
      end else if (r < 70) begin
        add_word(CMD_QUERY, $urandom);
      end else if (r < 85) begin
        v = inserted[$urandom_range(0, inserted.size() - 1)];
        add_word(CMD_QUERY, $urandom_range(0, 1) ? v : ~v);
      end else begin
        v = 32'h1 << $urandom_range(0, VALUE_W - 1);
        case ($urandom_range(0, 3))
          0: add_word(CMD_QUERY, v);
          1: add_word(CMD_QUERY, ~v);
          2: add_word(CMD_QUERY, 32'h0);
          default: add_word(CMD_QUERY, 32'hFFFF_FFFF);
        endcase
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(word_q.size() == 0 && !start && words_sent == results_seen))
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (owed_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, owed_results.size());
    end
    if (mismatches == 0) begin
      $display("binary_trie_max_xor verification clean");
    end else begin
      $display("binary_trie_max_xor verification failed");
    end
    $finish;
  end

endmodule
